@@ rtl/core/mali_pkg.sv @@
// Package for the multi-axis linear interpolator: request/result structs,
// register indexes, opcodes, defaults and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package mali_pkg;

  localparam int AXES_DEF      = 4;
  localparam int POS_WIDTH_DEF = 16;
  localparam int IN_AXES       = 4;   // axes that carry a request/result field
  localparam int FIELD_W       = 16;
  localparam int STEP_W        = 6;
  localparam int STEPS_W       = 7;
  localparam int AXCFG_W       = 3;
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int MAX_STEPS     = 64;

  localparam logic [STEPS_W-1:0] STEPS_RESET = 7'd10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_STEPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_AXES  = 1'd1;

  // opcodes
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  typedef struct packed {
    logic                      operation;
    logic signed [FIELD_W-1:0] axis_value_0;
    logic signed [FIELD_W-1:0] axis_value_1;
    logic signed [FIELD_W-1:0] axis_value_2;
    logic signed [FIELD_W-1:0] axis_value_3;
  } cmd_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] pos_0;
    logic signed [FIELD_W-1:0] pos_1;
    logic signed [FIELD_W-1:0] pos_2;
    logic signed [FIELD_W-1:0] pos_3;
    logic        [STEP_W-1:0]  step_index;
    logic                      last;
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_STEP,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/core/multi_axis_linear_interpolator.sv @@
// Multi-axis linear interpolator, top level: sequencer, shared divide/step
// unit and per-axis state. Depends on mali_pkg.
`timescale 1ns / 1ps

// Usage
//   cmd channel (cmd_valid/cmd_ready/cmd): one request per set or move.
//   step channel (step_valid/step_ready/step): one result per interpolation
//   point of a move; step.last flags the final point.
//   cfg port: cfg_we/cfg_index/cfg_data, to be written only while idle;
//   the user is bound to this, the block itself does not enforce it.
// Sequence (S = motion_steps): a set request, or a move with no axis moving,
//   is taken while idle and gives no result.
//   move request: one restoring divide per axis of |target-start| by S-1
//   (clamped to 1..63) on the shared unit, one quotient bit a cycle.
//   Then each point runs the shared add/compare once per active axis, in
//   turn, then shows the result on the step port.
//   cmd_ready is high only between moves.
// Reset: positions cleared to zero, motion_steps = 10, active_axes = AXES.
// Stall: a result holds on the step port until taken; nothing else moves.
module multi_axis_linear_interpolator #(
  parameter int AXES      = mali_pkg::AXES_DEF,
  parameter int POS_WIDTH = mali_pkg::POS_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  mali_pkg::cmd_t                      cmd,
  output logic                                step_valid,
  input  logic                                step_ready,
  output mali_pkg::step_t                     step,
  input  logic                                cfg_we,
  input  logic [mali_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mali_pkg::CFG_W-1:0]          cfg_data
);

  localparam int W   = POS_WIDTH;
  localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int BW  = $clog2(W + 1);
  localparam int SW  = mali_pkg::STEP_W;

  mali_pkg::state_t state, state_next;

  // configuration
  logic [mali_pkg::STEPS_W-1:0] motion_steps;
  logic [mali_pkg::AXCFG_W:0]   active_axes;   // one spare bit holds AXES = 8

  // sequencer counters
  logic [AXW-1:0] ax, ax_next;
  logic [BW-1:0]  bitcnt;
  logic [SW-1:0]  k, k_next;

  // divider
  logic [SW-1:0]  rem;
  logic [W:0]     dvd;

  // per-axis state
  logic signed [W-1:0] position [AXES];
  logic signed [W-1:0] start    [AXES];
  logic signed [W-1:0] goal     [AXES];
  logic                neg      [AXES];
  logic [W:0]          qd       [AXES];
  logic [SW-1:0]       rd       [AXES];
  logic [W:0]          q        [AXES];
  logic [SW-1:0]       r        [AXES];

  // effective config
  logic [SW-1:0]  den;
  logic [AXW-1:0] n_last;

  always_comb begin
    if (motion_steps < 7'd2) begin
      den = SW'(1);
    end else if (int'(motion_steps) > mali_pkg::MAX_STEPS) begin
      den = SW'(mali_pkg::MAX_STEPS - 1);
    end else begin
      den = SW'(motion_steps - 7'd1);
    end
    if (active_axes == '0) begin
      n_last = '0;
    end else if (int'(active_axes) > AXES) begin
      n_last = AXW'(AXES - 1);
    end else begin
      n_last = AXW'(active_axes - 4'd1);
    end
  end

  // request fields per axis, resized to the position width
  logic signed [mali_pkg::FIELD_W-1:0] in_raw [mali_pkg::IN_AXES];
  logic signed [W-1:0]                 in_val [AXES];
  logic [AXES-1:0]                     diff_vec;
  logic                                moves;

  assign in_raw[0] = cmd.axis_value_0;
  assign in_raw[1] = cmd.axis_value_1;
  assign in_raw[2] = cmd.axis_value_2;
  assign in_raw[3] = cmd.axis_value_3;

  for (genvar a = 0; a < AXES; a++) begin : g_in
    if (a < mali_pkg::IN_AXES) begin : g_field
      assign in_val[a] = W'(in_raw[a]);
    end else begin : g_zero
      assign in_val[a] = '0;
    end
    assign diff_vec[a] = (a <= int'(n_last)) && (in_val[a] != position[a]);
  end
  assign moves = |diff_vec;

  // shared unit: one 7-bit trial subtract of the divisor, muxed between
  // the divide iteration and the per-step remainder update
  logic [SW:0]   sub_a;
  logic [SW:0]   sub_d;
  logic          geq;
  logic [SW-1:0] sub_res;
  logic [W:0]    q_new;
  logic [SW-1:0] r_new;
  logic [W-1:0]  offs;
  logic signed [W-1:0] pos_new;
  logic signed [W:0]   delta;
  logic [W:0]          mag;

  always_comb begin
    if (state == mali_pkg::ST_DIV) begin
      sub_a = {rem, dvd[W]};
    end else begin
      sub_a = {1'b0, r[ax]} + {1'b0, rd[ax]};
    end
    geq     = sub_a >= {1'b0, den};
    sub_d   = sub_a - {1'b0, den};
    sub_res = geq ? sub_d[SW-1:0] : sub_a[SW-1:0];

    // delta of the selected axis
    delta = (W+1)'(goal[ax]) - (W+1)'(start[ax]);
    mag   = delta[W] ? $unsigned(-delta) : $unsigned(delta);

    // running quotient: q_k = round(|delta| * k / den)
    if (k == '0) begin
      q_new = '0;
      r_new = den >> 1;
    end else begin
      q_new = q[ax] + qd[ax] + (W+1)'(geq);
      r_new = sub_res;
    end
    offs    = neg[ax] ? (W'(0) - q_new[W-1:0]) : q_new[W-1:0];
    pos_new = $signed($unsigned(start[ax]) + offs);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mali_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ax_next    = ax;
    k_next     = k;
    cmd_ready  = 1'b0;
    step_valid = 1'b0;
    unique case (state)
      mali_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid && cmd.operation == mali_pkg::OP_MOVE && moves) begin
          state_next = mali_pkg::ST_LOAD;
          ax_next    = '0;
        end
      end
      mali_pkg::ST_LOAD: begin
        state_next = mali_pkg::ST_DIV;
      end
      mali_pkg::ST_DIV: begin
        if (bitcnt == BW'(W)) begin
          if (ax == n_last) begin
            state_next = mali_pkg::ST_STEP;
            ax_next    = '0;
            k_next     = '0;
          end else begin
            state_next = mali_pkg::ST_LOAD;
            ax_next    = ax + AXW'(1);
          end
        end
      end
      mali_pkg::ST_STEP: begin
        if (ax == n_last) begin
          state_next = mali_pkg::ST_EMIT;
        end else begin
          ax_next = ax + AXW'(1);
        end
      end
      mali_pkg::ST_EMIT: begin
        step_valid = 1'b1;
        if (step_ready) begin
          if (k == den) begin
            state_next = mali_pkg::ST_IDLE;
          end else begin
            state_next = mali_pkg::ST_STEP;
            ax_next    = '0;
            k_next     = k + SW'(1);
          end
        end
      end
      default: begin
        state_next = mali_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_steps <= mali_pkg::STEPS_RESET;
      active_axes  <= (mali_pkg::AXCFG_W+1)'(AXES);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mali_pkg::REG_MOTION_STEPS: motion_steps <= cfg_data;
        mali_pkg::REG_ACTIVE_AXES:  active_axes  <= {1'b0, cfg_data[mali_pkg::AXCFG_W-1:0]};
        default: ;
      endcase
    end
  end

  // counters and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      ax     <= '0;
      k      <= '0;
      bitcnt <= '0;
    end else begin
      ax <= ax_next;
      k  <= k_next;
      if (state == mali_pkg::ST_LOAD) begin
        bitcnt <= '0;
      end else if (state == mali_pkg::ST_DIV) begin
        bitcnt <= bitcnt + BW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mali_pkg::ST_LOAD) begin
      dvd <= mag;
      rem <= '0;
    end else if (state == mali_pkg::ST_DIV) begin
      dvd <= {dvd[W-1:0], geq};
      rem <= sub_res;
    end
  end

  // per-axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        position[a] <= '0;
        start[a]    <= '0;
        goal[a]     <= '0;
      end
    end else begin
      if (state == mali_pkg::ST_IDLE && cmd_valid) begin
        for (int a = 0; a < AXES; a++) begin
          if (a <= int'(n_last)) begin
            if (cmd.operation == mali_pkg::OP_SET) begin
              position[a] <= in_val[a];
            end else begin
              start[a] <= position[a];
              goal[a]  <= in_val[a];
            end
          end
        end
      end else if (state == mali_pkg::ST_STEP) begin
        position[ax] <= pos_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == mali_pkg::ST_LOAD) begin
      neg[ax] <= delta[W];
    end
    if (state == mali_pkg::ST_DIV && bitcnt == BW'(W)) begin
      qd[ax] <= {dvd[W-1:0], geq};
      rd[ax] <= sub_res;
    end
    if (state == mali_pkg::ST_STEP) begin
      q[ax] <= q_new;
      r[ax] <= r_new;
    end
  end

  // result
  logic signed [mali_pkg::FIELD_W-1:0] pos_out [mali_pkg::IN_AXES];

  for (genvar a = 0; a < mali_pkg::IN_AXES; a++) begin : g_out
    if (a < AXES) begin : g_axis
      assign pos_out[a] = mali_pkg::FIELD_W'(position[a]);
    end else begin : g_none
      assign pos_out[a] = '0;
    end
  end

  assign step.pos_0      = pos_out[0];
  assign step.pos_1      = pos_out[1];
  assign step.pos_2      = pos_out[2];
  assign step.pos_3      = pos_out[3];
  assign step.step_index = k;
  assign step.last       = (k == den);

`ifndef ASSERT_OFF
  // divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == mali_pkg::ST_DIV |-> rem < den)
    else $error("divider remainder out of range");

  // running remainder stays below the divisor between points
  a_step_rem: assert property (@(posedge clk) disable iff (rst)
    (state == mali_pkg::ST_STEP && k != '0) |-> r[ax] < den)
    else $error("step remainder out of range");

  // final point lands exactly on the target
  a_final: assert property (@(posedge clk) disable iff (rst)
    (state == mali_pkg::ST_STEP && k == den) |-> q_new == mag)
    else $error("final point misses target");

  // after the final point is taken the block returns to idle
  a_done: assert property (@(posedge clk) disable iff (rst)
    (step_valid && step_ready && step.last) |=> state == mali_pkg::ST_IDLE)
    else $error("move did not end after last point");
`endif

endmodule
